@@ hdl/assert_macros.svh @@
// Assertion macros shared by the counter table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/pmtc_pkg.sv @@
// Package with types and codes of the per-MAC traffic counter table.
`timescale 1ns / 1ps
`default_nettype none
package pmtc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int MAC_W   = 48;
    localparam int TOT_W   = 64;
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;
    localparam int INT_W   = 32;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NEW   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_PEND
    } state_t;

    // Request word traveling down the cell row. Once found is set, mac and
    // the totals carry the result instead of the request.
    typedef struct packed {
        logic [1:0]       op;
        logic [MAC_W-1:0] mac;
        logic [TOT_W-1:0] pkts;
        logic [TOT_W-1:0] bytes;
        logic [IDX_W-1:0] ridx;
        logic             found;
        logic             created;
        logic [IDX_W-1:0] idx;
    } token_t;

endpackage
`default_nettype wire

@@ hdl/pmtc_cell.sv @@
// One table slot: holds an entry and serves the request word passing by.
`timescale 1ns / 1ps
`default_nettype none
module pmtc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CNT_W-1:0]     fill,
    input  wire logic                 tok_in_valid,
    input  wire pmtc_pkg::token_t     tok_in,
    output logic                      tok_out_valid,
    output pmtc_pkg::token_t          tok_out
);

    logic [pmtc_pkg::MAC_W-1:0] key_reg, key_next;
    logic [pmtc_pkg::TOT_W-1:0] pkt_reg, pkt_next;
    logic [pmtc_pkg::TOT_W-1:0] byt_reg, byt_next;
    logic                       wr_en;
    logic                       occupied;
    logic                       at_fill;
    logic                       idx_hit;
    logic                       valid_reg;
    pmtc_pkg::token_t           tok_reg, tok_next;

    assign occupied = {{(pmtc_pkg::INT_W-CNT_W){1'b0}}, fill} > pmtc_pkg::INT_W'(CELL_INDEX);
    assign at_fill  = {{(pmtc_pkg::INT_W-CNT_W){1'b0}}, fill} == pmtc_pkg::INT_W'(CELL_INDEX);
    assign idx_hit  = {{(pmtc_pkg::INT_W-pmtc_pkg::IDX_W){1'b0}}, tok_in.ridx}
                      == pmtc_pkg::INT_W'(CELL_INDEX);

    always_comb
    begin
        tok_next = tok_in;
        wr_en    = 1'b0;
        key_next = key_reg;
        pkt_next = pkt_reg;
        byt_next = byt_reg;
        if (tok_in_valid && !tok_in.found)
        begin
            unique case (tok_in.op)
                pmtc_pkg::REQ_ADD:
                begin
                    priority if (occupied && key_reg == tok_in.mac)
                    begin
                        pkt_next       = pkt_reg + tok_in.pkts;
                        byt_next       = byt_reg + tok_in.bytes;
                        wr_en          = 1'b1;
                        tok_next.pkts  = pkt_next;
                        tok_next.bytes = byt_next;
                        tok_next.found = 1'b1;
                        tok_next.idx   = pmtc_pkg::IDX_W'(CELL_INDEX);
                    end
                    else if (at_fill)
                    begin
                        // First free slot: allocate it for this address.
                        key_next         = tok_in.mac;
                        pkt_next         = tok_in.pkts;
                        byt_next         = tok_in.bytes;
                        wr_en            = 1'b1;
                        tok_next.found   = 1'b1;
                        tok_next.created = 1'b1;
                        tok_next.idx     = pmtc_pkg::IDX_W'(CELL_INDEX);
                    end
                    else
                    begin
                        tok_next = tok_in;
                    end
                end
                pmtc_pkg::REQ_READ:
                begin
                    if (occupied && idx_hit)
                    begin
                        tok_next.mac   = key_reg;
                        tok_next.pkts  = pkt_reg;
                        tok_next.bytes = byt_reg;
                        tok_next.found = 1'b1;
                        tok_next.idx   = pmtc_pkg::IDX_W'(CELL_INDEX);
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg <= key_next;
            pkt_reg <= pkt_next;
            byt_reg <= byt_next;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_in_valid;
        end
    end

    assign tok_out_valid = valid_reg;
    assign tok_out       = tok_reg;

endmodule
`default_nettype wire

@@ hdl/per_mac_traffic_counter_table_top.sv @@
// Top level of the per-MAC traffic counter table: request intake, cell row, result output.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one request word: req_type selects add,
//   read or clear; mac_key, add_packets and add_bytes serve add, read_index serves read.
//   Output channel (out_valid / out_stall) returns exactly one result word per request.
//   A request walks the row of TABLE_DEPTH slot cells, one cell per cycle; each cell
//   compares, updates, allocates or reads its own entry as the word passes.
//   The result passes from the last cell into a holding register and from there into
//   the output register. One request is in flight at a time, so the block takes no new
//   request until the result of the last one has moved into the output register.
//   in_stall is high while a request is in flight. The finished result then waits in a
//   holding register until the output register is free, so a new request is taken while
//   an earlier result still sits stalled at the output.
//   Reset empties the table (entry count zero) and clears all valid flags; slot contents
//   need no clearing since only occupied slots are ever examined.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module per_mac_traffic_counter_table_top #(
    parameter int TABLE_DEPTH = pmtc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     req_type,
    input  wire logic [pmtc_pkg::MAC_W-1:0]     mac_key,
    input  wire logic [pmtc_pkg::TOT_W-1:0]     add_packets,
    input  wire logic [pmtc_pkg::TOT_W-1:0]     add_bytes,
    input  wire logic [pmtc_pkg::IDX_W-1:0]     read_index,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          status,
    output logic [pmtc_pkg::IDX_W-1:0]          entry_index,
    output logic [pmtc_pkg::MAC_W-1:0]          entry_mac,
    output logic [pmtc_pkg::TOT_W-1:0]          packet_total,
    output logic [pmtc_pkg::TOT_W-1:0]          byte_total,
    output logic [pmtc_pkg::COUNT_W-1:0]        entry_count
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    pmtc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic [TABLE_DEPTH:0] tv;
    pmtc_pkg::token_t     tok [0:TABLE_DEPTH];
    pmtc_pkg::token_t     tail;

    logic in_accept;
    logic pend_load;
    logic out_load;

    logic [1:0]                       pend_status_reg, pend_status_next;
    logic [pmtc_pkg::IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [pmtc_pkg::MAC_W-1:0]       pend_mac_reg, pend_mac_next;
    logic [pmtc_pkg::TOT_W-1:0]       pend_pkt_reg, pend_pkt_next;
    logic [pmtc_pkg::TOT_W-1:0]       pend_byt_reg, pend_byt_next;
    logic [pmtc_pkg::COUNT_W-1:0]     pend_cnt_reg;

    logic                             out_valid_reg;
    logic [1:0]                       out_status_reg;
    logic [pmtc_pkg::IDX_W-1:0]       out_idx_reg;
    logic [pmtc_pkg::MAC_W-1:0]       out_mac_reg;
    logic [pmtc_pkg::TOT_W-1:0]       out_pkt_reg;
    logic [pmtc_pkg::TOT_W-1:0]       out_byt_reg;
    logic [pmtc_pkg::COUNT_W-1:0]     out_cnt_reg;

    // Request word entering the first cell.
    assign in_accept = in_valid && !in_stall;
    assign tv[0]     = in_accept;

    always_comb
    begin
        tok[0]         = '0;
        tok[0].op      = req_type;
        tok[0].mac     = mac_key;
        tok[0].pkts    = add_packets;
        tok[0].bytes   = add_bytes;
        tok[0].ridx    = read_index;
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        pmtc_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .fill          (fill_reg),
            .tok_in_valid  (tv[i]),
            .tok_in        (tok[i]),
            .tok_out_valid (tv[i+1]),
            .tok_out       (tok[i+1])
        );
    end

    assign tail = tok[TABLE_DEPTH];

    // Control sequencer: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmtc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = pmtc_pkg::S_RUN;
                end
            end
            pmtc_pkg::S_RUN:
            begin
                if (tv[TABLE_DEPTH])
                begin
                    state_next = pmtc_pkg::S_PEND;
                end
            end
            pmtc_pkg::S_PEND:
            begin
                if (out_load)
                begin
                    state_next = pmtc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pmtc_pkg::S_IDLE;
            end
        endcase
    end

    // Control sequencer: outputs.
    always_comb
    begin
        in_stall  = (state_reg != pmtc_pkg::S_IDLE);
        pend_load = (state_reg == pmtc_pkg::S_RUN) && tv[TABLE_DEPTH];
        out_load  = (state_reg == pmtc_pkg::S_PEND) && (!out_valid_reg || !out_stall);
    end

    // Result formatting from the word leaving the last cell.
    always_comb
    begin
        pend_status_next = pmtc_pkg::STAT_OK;
        pend_idx_next    = '0;
        pend_mac_next    = '0;
        pend_pkt_next    = '0;
        pend_byt_next    = '0;
        fill_next        = fill_reg;
        unique case (tail.op)
            pmtc_pkg::REQ_ADD:
            begin
                if (tail.found)
                begin
                    pend_status_next = tail.created ? pmtc_pkg::STAT_NEW : pmtc_pkg::STAT_OK;
                    pend_idx_next    = tail.idx;
                    pend_mac_next    = tail.mac;
                    pend_pkt_next    = tail.pkts;
                    pend_byt_next    = tail.bytes;
                    if (tail.created)
                    begin
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    pend_status_next = pmtc_pkg::STAT_FULL;
                    pend_mac_next    = tail.mac;
                end
            end
            pmtc_pkg::REQ_READ:
            begin
                if (tail.found)
                begin
                    pend_idx_next = tail.idx;
                    pend_mac_next = tail.mac;
                    pend_pkt_next = tail.pkts;
                    pend_byt_next = tail.bytes;
                end
                else
                begin
                    pend_status_next = pmtc_pkg::STAT_EMPTY;
                    pend_idx_next    = tail.ridx;
                end
            end
            pmtc_pkg::REQ_CLEAR:
            begin
                fill_next = '0;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pmtc_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pend_load)
            begin
                fill_reg <= fill_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_load)
        begin
            pend_status_reg <= pend_status_next;
            pend_idx_reg    <= pend_idx_next;
            pend_mac_reg    <= pend_mac_next;
            pend_pkt_reg    <= pend_pkt_next;
            pend_byt_reg    <= pend_byt_next;
            pend_cnt_reg    <= pmtc_pkg::COUNT_W'(fill_next);
        end
        if (out_load)
        begin
            out_status_reg <= pend_status_reg;
            out_idx_reg    <= pend_idx_reg;
            out_mac_reg    <= pend_mac_reg;
            out_pkt_reg    <= pend_pkt_reg;
            out_byt_reg    <= pend_byt_reg;
            out_cnt_reg    <= pend_cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign entry_index  = out_idx_reg;
    assign entry_mac    = out_mac_reg;
    assign packet_total = out_pkt_reg;
    assign byte_total   = out_byt_reg;
    assign entry_count  = out_cnt_reg;

    `ASSERT_ALWAYS(a_one_word_in_row, $countones(tv) <= 1, "more than one request in the cell row")
    `ASSERT_ALWAYS(a_fill_limit, fill_reg <= CNT_W'(TABLE_DEPTH), "entry count exceeds table depth")
    `ASSERT_IMPLIES(a_tail_in_run, tv[TABLE_DEPTH], state_reg == pmtc_pkg::S_RUN, "row output outside a pass")
    `ASSERT_IMPLIES(a_out_from_pend, $rose(out_valid_reg), $past(state_reg) == pmtc_pkg::S_PEND, "result without a pending word")

endmodule
`default_nettype wire
